[hdl/nhbp_pkg.sv]
// ----------------------------------------------------------------------------
// nhbp_pkg
// Types and constants shared by the network header byte parser.
// ----------------------------------------------------------------------------
package nhbp_pkg;

   typedef enum logic [2:0] {
      PH_FIXED   = 3'd0,
      PH_HOPCNT  = 3'd1,
      PH_HOPLO   = 3'd2,
      PH_HOPHI   = 3'd3,
      PH_SECCTL  = 3'd4,
      PH_COUNTER = 3'd5,
      PH_KEYID   = 3'd6,
      PH_PAYLOAD = 3'd7
   } phase_type;

   localparam logic [1:0] KIND_HOP   = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_TRUNC = 2'd2;

   localparam logic [2:0] FIXED_LAST_POS   = 3'd6;
   localparam logic [2:0] COUNTER_END_POS  = 3'd4;
   localparam int         CTL_SECURITY_BIT = 6;
   localparam int         CTL_ROUTE_BIT    = 7;

   typedef struct packed {
      phase_type    phase;
      logic [2:0]   pos;
      logic [7:0]   control;
      logic [7:0]   sequence_num;
      logic [15:0]  dst;
      logic [15:0]  src;
      logic [7:0]   radius;
      logic [7:0]   hops;
      logic [7:0]   hop_lo;
      logic [7:0]   sec_ctl;
      logic [31:0]  counter;
      logic [7:0]   key;
      logic [9:0]   length;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_FIXED, pos: '0, control: '0, sequence_num: '0, dst: '0, src: '0,
      radius: '0, hops: '0, hop_lo: '0, sec_ctl: '0, counter: '0, key: '0,
      length: '0};

   typedef struct packed {
      logic [1:0]   kind;
      logic [7:0]   frame_control;
      logic [7:0]   sequence_number;
      logic [15:0]  dst_addr;
      logic [15:0]  src_addr;
      logic [7:0]   radius;
      logic [15:0]  hop_addr;
      logic [7:0]   security_control;
      logic [31:0]  frame_counter;
      logic         key_id_present;
      logic [7:0]   key_identifier;
      logic [9:0]   header_length;
   } result_type;

endpackage

[hdl/nhbp_step.sv]
// ----------------------------------------------------------------------------
// nhbp_step
// Per-byte parse step: next parser state and the result item, if any.
// ----------------------------------------------------------------------------
module nhbp_step (
   input  nhbp_pkg::state_type  cur_state,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output nhbp_pkg::state_type  next_state,
   output logic                 emit,
   output nhbp_pkg::result_type result
);
   import nhbp_pkg::*;

   state_type   upd;
   logic        complete;
   logic        have_hop;
   logic [15:0] hop;
   logic [2:0]  pos_inc;
   logic [7:0]  hops_dec;
   logic        key_present;
   logic [1:0]  kind;

   assign pos_inc  = cur_state.pos + 3'd1;
   assign hops_dec = cur_state.hops - 8'd1;

   always_comb begin
      upd      = cur_state;
      complete = 1'b0;
      have_hop = 1'b0;
      hop      = '0;
      if (cur_state.phase != PH_PAYLOAD) begin
         upd.length = cur_state.length + 10'd1;
      end
      case (cur_state.phase)
         PH_FIXED: begin
            case (cur_state.pos)
               3'd0: upd.control      = data_byte;
               3'd1: upd.sequence_num = data_byte;
               3'd2: upd.dst          = {8'h00, data_byte};
               3'd3: upd.dst          = cur_state.dst | {data_byte, 8'h00};
               3'd4: upd.src          = {8'h00, data_byte};
               3'd5: upd.src          = cur_state.src | {data_byte, 8'h00};
               default: upd.radius    = data_byte;
            endcase
            upd.pos = pos_inc;
            if (cur_state.pos == FIXED_LAST_POS) begin
               upd.pos = '0;
               if (upd.control[CTL_ROUTE_BIT]) begin
                  upd.phase = PH_HOPCNT;
               end else if (upd.control[CTL_SECURITY_BIT]) begin
                  upd.phase = PH_SECCTL;
               end else begin
                  upd.phase = PH_PAYLOAD;
                  complete  = 1'b1;
               end
            end
         end
         PH_HOPCNT: begin
            upd.hops = data_byte;
            if (data_byte != 8'h00) begin
               upd.phase = PH_HOPLO;
            end else if (cur_state.control[CTL_SECURITY_BIT]) begin
               upd.phase = PH_SECCTL;
            end else begin
               upd.phase = PH_PAYLOAD;
               complete  = 1'b1;
            end
         end
         PH_HOPLO: begin
            upd.hop_lo = data_byte;
            upd.phase  = PH_HOPHI;
         end
         PH_HOPHI: begin
            hop      = {data_byte, cur_state.hop_lo};
            have_hop = 1'b1;
            upd.hops = hops_dec;
            if (hops_dec != 8'h00) begin
               upd.phase = PH_HOPLO;
            end else if (cur_state.control[CTL_SECURITY_BIT]) begin
               upd.phase = PH_SECCTL;
            end else begin
               upd.phase = PH_PAYLOAD;
               complete  = 1'b1;
            end
         end
         PH_SECCTL: begin
            upd.sec_ctl = data_byte;
            upd.pos     = '0;
            upd.phase   = PH_COUNTER;
         end
         PH_COUNTER: begin
            upd.counter = cur_state.counter
                        | ({24'h000000, data_byte} << {cur_state.pos[1:0], 3'b000});
            upd.pos     = pos_inc;
            if (pos_inc >= COUNTER_END_POS) begin
               upd.pos = '0;
               if (cur_state.sec_ctl[3:2] != 2'b00) begin
                  upd.phase = PH_KEYID;
               end else begin
                  upd.phase = PH_PAYLOAD;
                  complete  = 1'b1;
               end
            end
         end
         PH_KEYID: begin
            upd.key   = data_byte;
            upd.phase = PH_PAYLOAD;
            complete  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      emit = 1'b1;
      kind = KIND_HOP;
      if (complete) begin
         kind = KIND_DONE;
      end else if (last_byte && upd.phase != PH_PAYLOAD) begin
         kind = KIND_TRUNC;
      end else if (!have_hop) begin
         emit = 1'b0;
      end
   end

   assign key_present = (upd.phase == PH_PAYLOAD) && upd.control[CTL_SECURITY_BIT]
                      && (upd.sec_ctl[3:2] != 2'b00);

   always_comb begin
      result.kind             = kind;
      result.frame_control    = upd.control;
      result.sequence_number  = upd.sequence_num;
      result.dst_addr         = upd.dst;
      result.src_addr         = upd.src;
      result.radius           = upd.radius;
      result.hop_addr         = (kind == KIND_TRUNC) ? 16'h0000 : hop;
      result.security_control = upd.sec_ctl;
      result.frame_counter    = upd.counter;
      result.key_id_present   = key_present;
      result.key_identifier   = key_present ? upd.key : 8'h00;
      result.header_length    = (kind == KIND_DONE) ? upd.length : 10'd0;
   end

   assign next_state = last_byte ? STATE_RESET : upd;

endmodule

[hdl/nwk_header_byte_parser_core.sv]
// ----------------------------------------------------------------------------
// nwk_header_byte_parser_core
// Byte-serial network frame header parser with one result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one frame byte per item; req_last_byte marks the final
//   byte of a frame, after which the next byte starts a new frame.
//   rsp_* carries a result item: a route hop, a header summary or a
//   truncated-header error. Most bytes produce no result.
//   Throughput: one byte per cycle while req_ready is high. The parse state
//   updates as a byte is accepted and any result is registered in the same
//   edge, so a result appears on rsp_* in the cycle after its byte.
//   A new byte is taken while the result register is empty or its item is
//   taken in that cycle; a stalled receiver holds req_ready low until the
//   pending item is taken.
//   Reset (synchronous) returns the parser to the start of a frame and
//   empties the result register.
// ----------------------------------------------------------------------------
module nwk_header_byte_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_frame_control,
   output logic [7:0]  rsp_sequence_number,
   output logic [15:0] rsp_dst_addr,
   output logic [15:0] rsp_src_addr,
   output logic [7:0]  rsp_radius,
   output logic [15:0] rsp_hop_addr,
   output logic [7:0]  rsp_security_control,
   output logic [31:0] rsp_frame_counter,
   output logic        rsp_key_id_present,
   output logic [7:0]  rsp_key_identifier,
   output logic [9:0]  rsp_header_length
);
   import nhbp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       emit;
   logic       rsp_valid_ff;
   logic       accept;

   nhbp_step u_step (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .next_state (state_in),
      .emit       (emit),
      .result     (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = result_ff.kind;
   assign rsp_frame_control    = result_ff.frame_control;
   assign rsp_sequence_number  = result_ff.sequence_number;
   assign rsp_dst_addr         = result_ff.dst_addr;
   assign rsp_src_addr         = result_ff.src_addr;
   assign rsp_radius           = result_ff.radius;
   assign rsp_hop_addr         = result_ff.hop_addr;
   assign rsp_security_control = result_ff.security_control;
   assign rsp_frame_counter    = result_ff.frame_counter;
   assign rsp_key_id_present   = result_ff.key_id_present;
   assign rsp_key_identifier   = result_ff.key_identifier;
   assign rsp_header_length    = result_ff.header_length;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks nwk_header_byte_parser_core. A short table of directed frames comes
// first, then random frames: well-formed, cut short, and loose noise bytes.
// The sender runs in bursts with random gaps. The receiver stalls on its own
// pattern. Every result item is compared, field by field, with a header
// parser model kept in this file.
// ----------------------------------------------------------------------------
module testbench;
   import nhbp_pkg::*;

   localparam int N_DIRECTED = 26;
   localparam int DRAIN_MID  = N_DIRECTED + 300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic [1:0] kind;
      logic [9:0] len;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_frame_control;
   logic [7:0]  rsp_sequence_number;
   logic [15:0] rsp_dst_addr;
   logic [15:0] rsp_src_addr;
   logic [7:0]  rsp_radius;
   logic [15:0] rsp_hop_addr;
   logic [7:0]  rsp_security_control;
   logic [31:0] rsp_frame_counter;
   logic        rsp_key_id_present;
   logic [7:0]  rsp_key_identifier;
   logic [9:0]  rsp_header_length;

   frame_byte_type frame_bytes[$];
   frame_byte_type directed_rows [0:N_DIRECTED-1];
   result_type     pending_results[$];
   int             bytes_sent;
   int             bytes_taken = 0;
   int             results_seen = 0;
   int             fail_count = 0;

   // header parser model state
   phase_type   hdr_phase = PH_FIXED;
   logic [2:0]  hdr_pos = '0;
   logic [7:0]  hdr_ctl = '0;
   logic [7:0]  hdr_seq = '0;
   logic [15:0] hdr_dst = '0;
   logic [15:0] hdr_src = '0;
   logic [7:0]  hdr_radius = '0;
   logic [7:0]  hdr_hops = '0;
   logic [7:0]  hdr_hop_lo = '0;
   logic [7:0]  hdr_sec = '0;
   logic [31:0] hdr_counter = '0;
   logic [7:0]  hdr_key = '0;
   logic [9:0]  hdr_len = '0;

   nwk_header_byte_parser_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_frame_control    (rsp_frame_control),
      .rsp_sequence_number  (rsp_sequence_number),
      .rsp_dst_addr         (rsp_dst_addr),
      .rsp_src_addr         (rsp_src_addr),
      .rsp_radius           (rsp_radius),
      .rsp_hop_addr         (rsp_hop_addr),
      .rsp_security_control (rsp_security_control),
      .rsp_frame_counter    (rsp_frame_counter),
      .rsp_key_id_present   (rsp_key_id_present),
      .rsp_key_identifier   (rsp_key_identifier),
      .rsp_header_length    (rsp_header_length)
   );

   always #5 clock = ~clock;

   function automatic void clear_parse_state();
      hdr_phase   = PH_FIXED;
      hdr_pos     = '0;
      hdr_ctl     = '0;
      hdr_seq     = '0;
      hdr_dst     = '0;
      hdr_src     = '0;
      hdr_radius  = '0;
      hdr_hops    = '0;
      hdr_hop_lo  = '0;
      hdr_sec     = '0;
      hdr_counter = '0;
      hdr_key     = '0;
      hdr_len     = '0;
   endfunction

   // route section done: go on to security, or the header is complete
   function automatic bit finish_route();
      if (hdr_ctl[CTL_SECURITY_BIT]) begin
         hdr_phase = PH_SECCTL;
         return 1'b0;
      end
      hdr_phase = PH_PAYLOAD;
      return 1'b1;
   endfunction

   task automatic parse_header_byte(input logic [7:0] b, input logic lst,
                                    output bit emits, output result_type r);
      bit          complete;
      bit          have_hop;
      bit          key_present;
      logic [15:0] hop;
      logic [1:0]  kind;
      complete = 1'b0;
      have_hop = 1'b0;
      hop      = '0;
      emits    = 1'b1;
      kind     = KIND_HOP;
      if (hdr_phase != PH_PAYLOAD) hdr_len = hdr_len + 10'd1;
      case (hdr_phase)
         PH_FIXED: begin
            case (hdr_pos)
               3'd0: hdr_ctl = b;
               3'd1: hdr_seq = b;
               3'd2: hdr_dst = {8'h00, b};
               3'd3: hdr_dst[15:8] = b;
               3'd4: hdr_src = {8'h00, b};
               3'd5: hdr_src[15:8] = b;
               default: hdr_radius = b;
            endcase
            if (hdr_pos == FIXED_LAST_POS) begin
               hdr_pos = '0;
               if (hdr_ctl[CTL_ROUTE_BIT]) hdr_phase = PH_HOPCNT;
               else complete = finish_route();
            end else begin
               hdr_pos = hdr_pos + 3'd1;
            end
         end
         PH_HOPCNT: begin
            hdr_hops = b;
            if (b == 8'h00) complete = finish_route();
            else hdr_phase = PH_HOPLO;
         end
         PH_HOPLO: begin
            hdr_hop_lo = b;
            hdr_phase  = PH_HOPHI;
         end
         PH_HOPHI: begin
            hop      = {b, hdr_hop_lo};
            have_hop = 1'b1;
            hdr_hops = hdr_hops - 8'd1;
            if (hdr_hops == 8'h00) complete = finish_route();
            else hdr_phase = PH_HOPLO;
         end
         PH_SECCTL: begin
            hdr_sec   = b;
            hdr_pos   = '0;
            hdr_phase = PH_COUNTER;
         end
         PH_COUNTER: begin
            hdr_counter = hdr_counter | (32'(b) << (8 * hdr_pos[1:0]));
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == COUNTER_END_POS) begin
               hdr_pos = '0;
               if (hdr_sec[3:2] != 2'b00) begin
                  hdr_phase = PH_KEYID;
               end else begin
                  hdr_phase = PH_PAYLOAD;
                  complete  = 1'b1;
               end
            end
         end
         PH_KEYID: begin
            hdr_key   = b;
            hdr_phase = PH_PAYLOAD;
            complete  = 1'b1;
         end
         default: ;
      endcase

      if (complete) kind = KIND_DONE;
      else if (lst && hdr_phase != PH_PAYLOAD) kind = KIND_TRUNC;
      else if (have_hop) kind = KIND_HOP;
      else emits = 1'b0;

      key_present = hdr_phase == PH_PAYLOAD && hdr_ctl[CTL_SECURITY_BIT] &&
                    hdr_sec[3:2] != 2'b00;
      r.kind             = kind;
      r.frame_control    = hdr_ctl;
      r.sequence_number  = hdr_seq;
      r.dst_addr         = hdr_dst;
      r.src_addr         = hdr_src;
      r.radius           = hdr_radius;
      r.hop_addr         = (kind == KIND_TRUNC) ? 16'h0000 : hop;
      r.security_control = hdr_sec;
      r.frame_counter    = hdr_counter;
      r.key_id_present   = key_present;
      r.key_identifier   = key_present ? hdr_key : 8'h00;
      r.header_length    = (kind == KIND_DONE) ? hdr_len : 10'd0;
      if (lst) clear_parse_state();
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   function automatic frame_byte_type plain_byte(input logic [7:0] d);
      frame_byte_type fb;
      fb = '{d, 1'b0, 1'b0, KIND_HOP, 10'd0};
      return fb;
   endfunction

   // results and byte prediction
   always @(posedge clock) begin
      result_type     got;
      result_type     want;
      result_type     pred;
      bit             emits;
      frame_byte_type row;
      if (reset) begin
         clear_parse_state();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got.kind             = rsp_result_kind;
            got.frame_control    = rsp_frame_control;
            got.sequence_number  = rsp_sequence_number;
            got.dst_addr         = rsp_dst_addr;
            got.src_addr         = rsp_src_addr;
            got.radius           = rsp_radius;
            got.hop_addr         = rsp_hop_addr;
            got.security_control = rsp_security_control;
            got.frame_counter    = rsp_frame_counter;
            got.key_id_present   = rsp_key_id_present;
            got.key_identifier   = rsp_key_identifier;
            got.header_length    = rsp_header_length;
            if (pending_results.size() == 0) begin
               $error("result item with none expected, kind %0d", got.kind);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(got.kind));
               check_field("frame_control", 32'(want.frame_control),
                           32'(got.frame_control));
               check_field("sequence_number", 32'(want.sequence_number),
                           32'(got.sequence_number));
               check_field("dst_addr", 32'(want.dst_addr), 32'(got.dst_addr));
               check_field("src_addr", 32'(want.src_addr), 32'(got.src_addr));
               check_field("radius", 32'(want.radius), 32'(got.radius));
               check_field("hop_addr", 32'(want.hop_addr), 32'(got.hop_addr));
               check_field("security_control", 32'(want.security_control),
                           32'(got.security_control));
               check_field("frame_counter", want.frame_counter, got.frame_counter);
               check_field("key_id_present", 32'(want.key_id_present),
                           32'(got.key_id_present));
               check_field("key_identifier", 32'(want.key_identifier),
                           32'(got.key_identifier));
               check_field("header_length", 32'(want.header_length),
                           32'(got.header_length));
            end
         end
         if (req_valid && req_ready) begin
            parse_header_byte(req_data_byte, req_last_byte, emits, pred);
            row = frame_bytes[bytes_taken];
            if (row.typed) begin
               pred.kind          = row.kind;
               pred.header_length = row.len;
               pending_results = {pending_results, pred};
            end else if (emits) begin
               pending_results = {pending_results, pred};
            end
            bytes_taken++;
         end
      end
   end

   // sender: bursts and gaps, pauses for a full drain at two points
   int burst_left;
   int gap_left;
   int drained_at = -1;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         bytes_sent = 0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) bytes_sent++;
         if (!(req_valid && !req_ready)) begin
            if (bytes_sent >= frame_bytes.size()) begin
               req_valid <= 1'b0;
            end else if ((bytes_sent == N_DIRECTED || bytes_sent == DRAIN_MID) &&
                         drained_at != bytes_sent) begin
               req_valid <= 1'b0;
               if (!(req_valid && req_ready) && pending_results.size() == 0)
                  drained_at = bytes_sent;
            end else if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid     <= 1'b1;
               req_data_byte <= frame_bytes[bytes_sent].data;
               req_last_byte <= frame_bytes[bytes_sent].last;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // receiver: rotating stall pattern plus one long hold-off
   int unsigned ready_cyc;
   int          hold_left;
   bit          hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_cyc = 0;
         hold_left = 0;
      end else begin
         ready_cyc++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_valid && results_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = 200;
            rsp_ready <= 1'b0;
         end else begin
            case ((ready_cyc / 64) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (ready_cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      #3000000;
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      frame_byte_type fq[$];
      logic [7:0]     ctl;
      logic [7:0]     sec;
      int             nhops;
      int             npay;
      int             hlen;
      int             cut;
      int             choice;
      int             frames;

      // route with two hops, the last hop ends the header on the last byte;
      // security with key; a one-byte frame cut short
      directed_rows = '{
         '{8'h80, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h02, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b1, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b1, 1'b1, KIND_DONE,  10'd12},
         '{8'h7F, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h0C, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hFF, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'h00, 1'b0, 1'b0, KIND_HOP,   10'd0},
         '{8'hA5, 1'b1, 1'b1, KIND_DONE,  10'd13},
         '{8'hFF, 1'b1, 1'b1, KIND_TRUNC, 10'd0}
      };
      for (int i = 0; i < N_DIRECTED; i++) frame_bytes = {frame_bytes, directed_rows[i]};

      frames = 0;
      while (frame_bytes.size() < N_DIRECTED + 575) begin
         choice = $urandom_range(0, 9);
         if (frames == 5) choice = 2;
         if (choice == 0) begin
            fq.delete();
            fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
            fq[0].last = ($urandom_range(0, 3) == 0);
         end else begin
            fq.delete();
            ctl = 8'($urandom_range(0, 255));
            if (frames == 5) ctl[CTL_ROUTE_BIT] = 1'b1;
            fq = {fq, plain_byte(ctl)};
            for (int i = 0; i < 6; i++) fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
            if (ctl[CTL_ROUTE_BIT]) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: nhops = $urandom_range(0, 3);
                  6, 7, 8: nhops = $urandom_range(4, 12);
                  default: nhops = $urandom_range(13, 40);
               endcase
               if (frames == 5) nhops = 255;
               fq = {fq, plain_byte(8'(nhops))};
               for (int i = 0; i < 2 * nhops; i++)
                  fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
            end
            if (ctl[CTL_SECURITY_BIT]) begin
               sec = 8'($urandom_range(0, 255));
               fq = {fq, plain_byte(sec)};
               for (int i = 0; i < 4; i++)
                  fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
               if (sec[3:2] != 2'b00) fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
            end
            hlen = fq.size();
            if (choice == 1) begin
               cut = $urandom_range(1, hlen - 1);
               while (fq.size() > cut) void'(fq.pop_back());
            end else begin
               npay = $urandom_range(0, 4);
               for (int i = 0; i < npay; i++)
                  fq = {fq, plain_byte(8'($urandom_range(0, 255)))};
            end
            fq[fq.size() - 1].last = 1'b1;
            frames++;
         end
         foreach (fq[i]) frame_bytes = {frame_bytes, fq[i]};
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (bytes_taken == frame_bytes.size());
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/nhbp_pkg.sv
hdl/nhbp_step.sv
hdl/nwk_header_byte_parser_core.sv
tb/sv/testbench.sv
